// ===== hdl/spring_distance_constraint_core_assert.svh =====
// Assertion macros shared by the spring constraint core.
// Both are sampled on the rising clock and ignored while reset is held.
`ifndef SPRING_DISTANCE_CONSTRAINT_CORE_ASSERT_SVH
`define SPRING_DISTANCE_CONSTRAINT_CORE_ASSERT_SVH

// Same-cycle implication.
`define SDC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spring constraint core check failed");

// Next-cycle implication.
`define SDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spring constraint core check failed");

`endif

// ===== hdl/sdc_pkg.sv =====
package sdc_pkg;

	// Position format and derived widths
	localparam int POS_WIDTH = 32;
	localparam int D_W       = POS_WIDTH + 1;          // delta and distance
	localparam int SQ_W      = 2 * D_W;                // squared distance
	localparam int MAX_W     = (D_W > 32) ? D_W : 32;
	localparam int OM_W      = MAX_W + 1;              // offset magnitude
	localparam int Q_W       = OM_W + 32;              // raw quotient
	localparam int FMAG_W    = 64;                     // factor magnitude, Q.32
	localparam int CORR_W    = 63;                     // capped correction magnitude

	// Configuration registers
	localparam int CFG_W     = 32;
	localparam int REST_W    = 32;
	localparam int STIFF_W   = 17;
	localparam int EPS_W     = 16;
	localparam int IDX_W     = 2;

	localparam logic [IDX_W-1:0] REG_REST_LENGTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_STIFFNESS   = 2'd1;
	localparam logic [IDX_W-1:0] REG_EPSILON     = 2'd2;

	localparam logic [REST_W-1:0]  REST_RESET  = 32'd65536;
	localparam logic [STIFF_W-1:0] STIFF_RESET = 17'd65536;
	localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd3;

	// Correction magnitude is capped at 2^62
	localparam logic [64:0] CORR_CAP = 65'h1 << 62;

	// Pipeline depth, input edge to result strobe
	localparam int CORR_STAGES = 5;
	localparam int LATENCY     = 3 + D_W + 1 + Q_W + 1 + CORR_STAGES;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0] first_x;
		logic signed [POS_WIDTH-1:0] first_y;
		logic signed [POS_WIDTH-1:0] second_x;
		logic signed [POS_WIDTH-1:0] second_y;
	} item_t;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0] new_first_x;
		logic signed [POS_WIDTH-1:0] new_first_y;
		logic signed [POS_WIDTH-1:0] new_second_x;
		logic signed [POS_WIDTH-1:0] new_second_y;
		logic                        saturated;
	} result_t;

	// Node A and the deltas travel with each transaction
	typedef struct packed {
		logic signed [POS_WIDTH-1:0] ax;
		logic signed [POS_WIDTH-1:0] ay;
		logic signed [D_W-1:0]       dx;
		logic signed [D_W-1:0]       dy;
	} carry_t;

	typedef struct packed {
		carry_t              c;
		logic                fneg;
		logic                below_eps;
		logic [FMAG_W-1:0]   raw_mag;
	} div_side_t;

	typedef struct packed {
		carry_t              c;
		logic                fneg;
		logic [FMAG_W-1:0]   fmag;
	} corr_in_t;

endpackage

// ===== hdl/spring_distance_constraint_core.sv =====
// Spring distance constraint core. Each transaction carries the positions of
// two nodes; the core returns both positions corrected toward the rest length,
// saturated to the position range. busy is always low: a transaction may start
// in every clock cycle, and its result appears with done high for one cycle
// at the end of the pipeline: three input stages, one stage per distance bit
// of the square root, one per quotient bit of the divider, then the offset and
// factor select registers and the correction stages. The receiver cannot stall
// the result. Write the registers only while idle.
`include "spring_distance_constraint_core_assert.svh"

module spring_distance_constraint_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  sdc_pkg::item_t              item,
	output logic                        done,
	output sdc_pkg::result_t            result,
	input  logic                        wr_en,
	input  logic [sdc_pkg::IDX_W-1:0]   wr_index,
	input  logic [sdc_pkg::CFG_W-1:0]   wr_data
);

	localparam int DW = sdc_pkg::D_W;
	localparam int SW = sdc_pkg::SQ_W;
	localparam int NW = sdc_pkg::OM_W;
	localparam int QW = sdc_pkg::Q_W;

	logic [sdc_pkg::REST_W-1:0]  rest_q;
	logic [sdc_pkg::STIFF_W-1:0] stiff_q;
	logic [sdc_pkg::EPS_W-1:0]   eps_q;

	logic                 accept;
	logic                 valid_s1, valid_s2, valid_s3, off_valid_s4, fsel_valid_s5;
	sdc_pkg::carry_t      side_s1, side_s2, side_s3;
	logic [DW-1:0]        mx, my;
	logic [SW-1:0]        sqx_s2, sqy_s2;
	logic [SW-1:0]        rad_s3;

	logic                 sq_valid;
	logic [DW-1:0]        sq_root;
	sdc_pkg::carry_t      sq_side;

	logic signed [NW:0]   off;
	logic [NW-1:0]        om;
	logic [NW-1:0]        om_s4;
	logic [DW-1:0]        d_s4;
	sdc_pkg::div_side_t   dside_s4;

	logic                 dv_valid;
	logic [QW-1:0]        dv_quot;
	sdc_pkg::div_side_t   dv_side;
	sdc_pkg::corr_in_t    fsel_s5;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_q  <= sdc_pkg::REST_RESET;
			stiff_q <= sdc_pkg::STIFF_RESET;
			eps_q   <= sdc_pkg::EPS_RESET;
		end else if (wr_en) begin
			case (wr_index)
				sdc_pkg::REG_REST_LENGTH: rest_q  <= wr_data[sdc_pkg::REST_W-1:0];
				sdc_pkg::REG_STIFFNESS:   stiff_q <= wr_data[sdc_pkg::STIFF_W-1:0];
				sdc_pkg::REG_EPSILON:     eps_q   <= wr_data[sdc_pkg::EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// front stages valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			off_valid_s4  <= 1'b0;
			fsel_valid_s5 <= 1'b0;
		end else begin
			valid_s1      <= accept;
			valid_s2      <= valid_s1;
			valid_s3      <= valid_s2;
			off_valid_s4  <= sq_valid;
			fsel_valid_s5 <= dv_valid;
		end
	end

	// delta, squares, sum
	assign mx = side_s1.dx[DW-1] ? DW'(-side_s1.dx) : DW'(side_s1.dx);
	assign my = side_s1.dy[DW-1] ? DW'(-side_s1.dy) : DW'(side_s1.dy);

	always_ff @(posedge clk) begin
		side_s1.ax <= item.first_x;
		side_s1.ay <= item.first_y;
		side_s1.dx <= DW'(item.second_x) - DW'(item.first_x);
		side_s1.dy <= DW'(item.second_y) - DW'(item.first_y);
		side_s2    <= side_s1;
		sqx_s2     <= SW'(mx) * SW'(mx);
		sqy_s2     <= SW'(my) * SW'(my);
		side_s3    <= side_s2;
		rad_s3     <= sqx_s2 + sqy_s2;
	end

	sdc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_rad    (rad_s3),
		.in_side   (side_s3),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// offset = rest - d, sign and magnitude
	assign off = $signed((NW+1)'(rest_q)) - $signed((NW+1)'(sq_root));
	assign om  = off[NW] ? NW'(-off) : NW'(off);

	always_ff @(posedge clk) begin
		om_s4              <= om;
		d_s4               <= sq_root;
		dside_s4.c         <= sq_side;
		dside_s4.fneg      <= off[NW];
		dside_s4.below_eps <= !(sq_root > DW'(eps_q));
		dside_s4.raw_mag   <= sdc_pkg::FMAG_W'({om, 16'b0});
	end

	sdc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (off_valid_s4),
		.in_num    (om_s4),
		.in_den    (d_s4),
		.in_side   (dside_s4),
		.out_valid (dv_valid),
		.out_quot  (dv_quot),
		.out_side  (dv_side)
	);

	// factor select: raw offset at small distance, quotient saturated to 64 bits
	always_ff @(posedge clk) begin
		fsel_s5.c    <= dv_side.c;
		fsel_s5.fneg <= dv_side.fneg;
		if (dv_side.below_eps) begin
			fsel_s5.fmag <= dv_side.raw_mag;
		end else if (|dv_quot[QW-1:sdc_pkg::FMAG_W]) begin
			fsel_s5.fmag <= '1;
		end else begin
			fsel_s5.fmag <= dv_quot[sdc_pkg::FMAG_W-1:0];
		end
	end

	sdc_corr u_corr (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (fsel_valid_s5),
		.in_data    (fsel_s5),
		.stiffness  (stiff_q),
		.out_valid  (done),
		.out_result (result)
	);

	// checks
	`SDC_ASSERT_IMPL(a_latency, accept, ##(sdc_pkg::LATENCY) done)
	`SDC_ASSERT_IMPL(a_no_stray_done, done, $past(accept, sdc_pkg::LATENCY))
	`SDC_ASSERT_IMPL(a_div_den_nonzero, off_valid_s4 && !dside_s4.below_eps, d_s4 != '0)
	`SDC_ASSERT_NEXT(a_rest_write, wr_en && wr_index == sdc_pkg::REG_REST_LENGTH, rest_q == $past(wr_data))

endmodule

// ===== hdl/sdc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module sdc_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [sdc_pkg::SQ_W-1:0]  in_rad,
	input  sdc_pkg::carry_t           in_side,
	output logic                      out_valid,
	output logic [sdc_pkg::D_W-1:0]   out_root,
	output sdc_pkg::carry_t           out_side
);

	localparam int N  = sdc_pkg::D_W;
	localparam int RW = N + 2;
	localparam int SW = sdc_pkg::SQ_W;

	logic [N:0]      valid_s;
	logic [SW-1:0]   rad_s  [0:N];
	logic [RW-1:0]   rem_s  [0:N];
	logic [N-1:0]    root_s [0:N];
	sdc_pkg::carry_t side_s [0:N];

	assign valid_s[0] = in_valid;
	assign rad_s[0]   = in_rad;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic          take;

		// bring down the next bit pair and try root*4+1
		assign cur   = {rem_s[k], rad_s[k][SW-1 -: 2]};
		assign trial = {{(RW-N){1'b0}}, root_s[k], 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= {rad_s[k][SW-3:0], 2'b00};
			rem_s[k+1]  <= take ? RW'(cur - trial) : RW'(cur);
			root_s[k+1] <= {root_s[k][N-2:0], take};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[N];
	assign out_root  = root_s[N];
	assign out_side  = side_s[N];

endmodule

// ===== hdl/sdc_div.sv =====
// Pipelined restoring divider: (num << 32) / den, one quotient bit per stage.
module sdc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [sdc_pkg::OM_W-1:0]  in_num,
	input  logic [sdc_pkg::D_W-1:0]   in_den,
	input  sdc_pkg::div_side_t        in_side,
	output logic                      out_valid,
	output logic [sdc_pkg::Q_W-1:0]   out_quot,
	output sdc_pkg::div_side_t        out_side
);

	localparam int N  = sdc_pkg::Q_W;
	localparam int DW = sdc_pkg::D_W;
	localparam int NW = sdc_pkg::OM_W;

	logic [N:0]         valid_s;
	logic [NW-1:0]      num_s  [0:N];
	logic [DW-1:0]      den_s  [0:N];
	logic [DW-1:0]      rem_s  [0:N];
	logic [N-1:0]       quot_s [0:N];
	sdc_pkg::div_side_t side_s [0:N];

	assign valid_s[0] = in_valid;
	assign num_s[0]   = in_num;
	assign den_s[0]   = in_den;
	assign rem_s[0]   = '0;
	assign quot_s[0]  = '0;
	assign side_s[0]  = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic          nbit;
		logic [DW:0]   cur;
		logic          take;

		// numerator bit of this stage; the low 32 bits are zero
		if (N - 1 - k >= 32) begin : g_hi
			assign nbit = num_s[k][N - 1 - k - 32];
		end else begin : g_lo
			assign nbit = 1'b0;
		end

		assign cur  = {rem_s[k], nbit};
		assign take = (cur >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			num_s[k+1]  <= num_s[k];
			den_s[k+1]  <= den_s[k];
			rem_s[k+1]  <= take ? DW'(cur - {1'b0, den_s[k]}) : DW'(cur);
			quot_s[k+1] <= {quot_s[k][N-2:0], take};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = valid_s[N];
	assign out_quot  = quot_s[N];
	assign out_side  = side_s[N];

endmodule

// ===== hdl/sdc_corr.sv =====
// Correction multiply, gain, cap and saturating position update for both axes.
module sdc_corr (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  sdc_pkg::corr_in_t            in_data,
	input  logic [sdc_pkg::STIFF_W-1:0]  stiffness,
	output logic                         out_valid,
	output sdc_pkg::result_t             out_result
);

	localparam int PW  = sdc_pkg::POS_WIDTH;
	localparam int DW  = sdc_pkg::D_W;
	localparam int ML  = DW + 32;
	localparam int QLW = 32 + sdc_pkg::STIFF_W;
	localparam int QHW = (ML - 32) + sdc_pkg::STIFF_W;
	localparam int CW  = sdc_pkg::CORR_W;
	localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (PW - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

	// {clipped, value}
	function automatic logic [PW:0] sat(input logic signed [63:0] v);
		logic [PW:0] r;
		begin
			if (v > SAT_HI) begin
				r = {1'b1, SAT_HI[PW-1:0]};
			end else if (v < SAT_LO) begin
				r = {1'b1, SAT_LO[PW-1:0]};
			end else begin
				r = {1'b0, v[PW-1:0]};
			end
			return r;
		end
	endfunction

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	sdc_pkg::corr_in_t side_s1, side_s2, side_s3, side_s4;

	logic signed [DW-1:0] delta_in [0:1];
	logic signed [DW-1:0] delta_s4 [0:1];
	logic [DW-1:0]        mag_in   [0:1];
	logic [ML-1:0]        pl_s1    [0:1];
	logic [ML-1:0]        ph_s1    [0:1];
	logic [ML-1:0]        t_s2     [0:1];
	logic [QLW-1:0]       ql_s3    [0:1];
	logic [QHW-1:0]       qh_s3    [0:1];
	logic [64:0]          csum     [0:1];
	logic [CW-1:0]        c_s4     [0:1];
	logic signed [63:0]   cs       [0:1];
	logic signed [63:0]   pos_a    [0:1];
	logic [PW:0]          new_a    [0:1];
	logic [PW:0]          new_b    [0:1];

	assign delta_in[0] = in_data.c.dx;
	assign delta_in[1] = in_data.c.dy;
	assign delta_s4[0] = side_s4.c.dx;
	assign delta_s4[1] = side_s4.c.dy;
	assign pos_a[0]    = 64'(side_s4.c.ax);
	assign pos_a[1]    = 64'(side_s4.c.ay);

	for (genvar j = 0; j < 2; j++) begin : g_lane
		// magnitude of delta
		assign mag_in[j] = delta_in[j][DW-1] ? DW'(-delta_in[j]) : DW'(delta_in[j]);

		// gain product shifted by 17 (Q1.16 and the halving), then capped
		assign csum[j] = 65'({qh_s3[j], 15'b0}) + 65'(ql_s3[j] >> 17);

		// signed correction, subtract from A, add to B
		assign cs[j]    = (delta_s4[j][DW-1] ^ side_s4.fneg) ?
			-64'(c_s4[j]) : 64'(c_s4[j]);
		assign new_a[j] = sat(pos_a[j] - cs[j]);
		assign new_b[j] = sat(pos_a[j] + 64'(delta_s4[j]) + cs[j]);

		always_ff @(posedge clk) begin
			pl_s1[j] <= ML'(mag_in[j]) * ML'(in_data.fmag[31:0]);
			ph_s1[j] <= ML'(mag_in[j]) * ML'(in_data.fmag[63:32]);
			t_s2[j]  <= ph_s1[j] + (pl_s1[j] >> 32);
			ql_s3[j] <= QLW'(t_s2[j][31:0]) * QLW'(stiffness);
			qh_s3[j] <= QHW'(t_s2[j][ML-1:32]) * QHW'(stiffness);
			c_s4[j]  <= (csum[j] > sdc_pkg::CORR_CAP) ?
				CW'(sdc_pkg::CORR_CAP) : CW'(csum[j]);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			out_valid <= valid_s4;
		end
	end

	// side data and output register
	always_ff @(posedge clk) begin
		side_s1 <= in_data;
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		out_result.new_first_x  <= new_a[0][PW-1:0];
		out_result.new_first_y  <= new_a[1][PW-1:0];
		out_result.new_second_x <= new_b[0][PW-1:0];
		out_result.new_second_y <= new_b[1][PW-1:0];
		out_result.saturated    <= new_a[0][PW] | new_a[1][PW] | new_b[0][PW] | new_b[1][PW];
	end

endmodule
